@@ hdl/cfd_pkg.sv @@
// ----------------------------------------------------------------------------
// cfd_pkg: shared types and constants for the complex FIR decimator
// Widths, opcodes, cell-to-cell structs and the output round/saturate helper.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

    localparam int NUM_TAPS = 32;
    localparam int SMP_W    = 16;
    localparam int COEF_W   = 16;
    localparam int IDX_W    = 5;
    localparam int DEC_W    = 5;
    localparam int PHASE_W  = 4;
    localparam int FRAC_W   = 15;
    localparam int PROD_W   = SMP_W + COEF_W;
    localparam int ACC_W    = PROD_W + $clog2(NUM_TAPS) + 1;
    localparam int DEC_MAX  = 16;

    localparam logic signed [ACC_W-1:0] RND_OFS = ACC_W'(2 ** (FRAC_W - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'(2 ** (SMP_W - 1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO  = ~SAT_HI;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_COEF   = 1'b1
    } t_op;

    typedef struct packed {
        logic signed [SMP_W-1:0] i;
        logic signed [SMP_W-1:0] q;
    } t_iq;

    typedef struct packed {
        logic                    vld;
        logic signed [ACC_W-1:0] acc_i;
        logic signed [ACC_W-1:0] acc_q;
    } t_psum;

    typedef struct packed {
        logic signed [SMP_W-1:0] val;
        logic                    clip;
    } t_sat;

    // round half up, floor shift, saturate to SMP_W bits
    function automatic t_sat sat_q15(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] shf;
        t_sat                    res;
        shf = (acc + RND_OFS) >>> FRAC_W;
        if (shf > SAT_HI) begin
            res.val  = SAT_HI[SMP_W-1:0];
            res.clip = 1'b1;
        end else if (shf < SAT_LO) begin
            res.val  = SAT_LO[SMP_W-1:0];
            res.clip = 1'b1;
        end else begin
            res.val  = shf[SMP_W-1:0];
            res.clip = 1'b0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hdl/cfd_cell.sv @@
// ----------------------------------------------------------------------------
// cfd_cell: one tap of the complex FIR chain
// Holds one window sample and one coefficient; adds its product into the
// partial sum passing from the previous cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_shift,
    input  wire cfd_pkg::t_iq                  i_smp,
    output      cfd_pkg::t_iq                  o_smp,
    input  wire logic                          i_coef_we,
    input  wire logic signed [cfd_pkg::COEF_W-1:0] i_coef,
    input  wire cfd_pkg::t_psum                i_psum,
    input  wire logic                          i_take,
    output      cfd_pkg::t_psum                o_psum
);

    cfd_pkg::t_iq                          r_smp, n_smp;
    logic signed [cfd_pkg::COEF_W-1:0]     r_coef, n_coef;
    cfd_pkg::t_psum                        r_psum, n_psum;
    logic signed [cfd_pkg::PROD_W-1:0]     w_prod_i, w_prod_q;

    assign w_prod_i = r_coef * r_smp.i;
    assign w_prod_q = r_coef * r_smp.q;

    always_comb begin
        n_smp  = i_shift ? i_smp : r_smp;
        n_coef = i_coef_we ? i_coef : r_coef;
        n_psum = r_psum;
        if (i_psum.vld) begin
            n_psum.vld   = 1'b1;
            n_psum.acc_i = i_psum.acc_i
                + {{(cfd_pkg::ACC_W-cfd_pkg::PROD_W){w_prod_i[cfd_pkg::PROD_W-1]}}, w_prod_i};
            n_psum.acc_q = i_psum.acc_q
                + {{(cfd_pkg::ACC_W-cfd_pkg::PROD_W){w_prod_q[cfd_pkg::PROD_W-1]}}, w_prod_q};
        end else if (i_take) begin
            n_psum.vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp      <= '0;
            r_coef     <= '0;
            r_psum.vld <= 1'b0;
        end else begin
            r_smp      <= n_smp;
            r_coef     <= n_coef;
            r_psum.vld <= n_psum.vld;
        end
        r_psum.acc_i <= n_psum.acc_i;
        r_psum.acc_q <= n_psum.acc_q;
    end

    assign o_smp  = r_smp;
    assign o_psum = r_psum;

endmodule

`default_nettype wire

@@ hdl/complex_fir_decimator.sv @@
// ----------------------------------------------------------------------------
// complex_fir_decimator: decimating complex I/Q FIR, Q1.15
// A non-emitting sample or a coefficient write is taken without a stall.
// An emitting sample stalls the input: tready drops while r_start is set
// and for the partial sum's walk down the chain, one cell per cycle.
// Output tvalid rises when the last cell's sum enters the output register;
// a full output register holds the last cell and stretches the stall.
// Synchronous active-low reset clears samples, coefficients, phase; factor=1.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_fir_decimator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_data,     // decimation_factor
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // [15:0] sample_i, [31:16] sample_q, [36:32] tap_index, [52:37] tap_value
    input  wire logic [55:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,   // [0] opcode
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata,   // [15:0] out_i, [31:16] out_q
    output      logic        m_axis_tuser    // [0] clipped
);

    localparam int N = cfd_pkg::NUM_TAPS;

    logic [cfd_pkg::DEC_W-1:0]   r_dec, n_dec;
    logic [cfd_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic                        r_start, n_start;
    logic                        r_out_vld, n_out_vld;
    logic signed [cfd_pkg::SMP_W-1:0] r_out_i, r_out_q;
    logic                        r_out_clip;

    cfd_pkg::t_iq   w_smp   [N+1];
    cfd_pkg::t_psum w_psum  [N+1];
    logic [N-1:0]   w_vld;
    logic           w_busy, w_acc, w_is_smp, w_is_coef, w_emit, w_load;
    logic [cfd_pkg::DEC_W-1:0]  w_factor;
    logic [cfd_pkg::PHASE_W:0]  w_phase_p1;
    logic [cfd_pkg::IDX_W-1:0]  w_idx;
    cfd_pkg::t_sat  w_sat_i, w_sat_q;

    assign w_busy        = r_start | (|w_vld);
    assign s_axis_tready = ~w_busy;
    assign w_acc         = s_axis_tvalid & s_axis_tready;
    assign w_is_smp      = w_acc & (cfd_pkg::t_op'(s_axis_tuser) == cfd_pkg::OP_SAMPLE);
    assign w_is_coef     = w_acc & (cfd_pkg::t_op'(s_axis_tuser) == cfd_pkg::OP_COEF);
    assign w_idx         = s_axis_tdata[36:32];
    assign w_emit        = (r_phase == '0);

    // new sample enters at the top cell; the window shifts toward cell 0
    assign w_smp[N].i = s_axis_tdata[15:0];
    assign w_smp[N].q = s_axis_tdata[31:16];

    assign w_psum[0].vld   = r_start;
    assign w_psum[0].acc_i = '0;
    assign w_psum[0].acc_q = '0;

    // last cell holds its sum until the output register can take it
    assign w_load = w_psum[N].vld & (~r_out_vld | m_axis_tready);

    genvar t;
    generate
        for (t = 0; t < N; t++) begin : g_cell
            cfd_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_shift   (w_is_smp),
                .i_smp     (w_smp[t+1]),
                .o_smp     (w_smp[t]),
                .i_coef_we (w_is_coef && (int'(w_idx) == t)),
                .i_coef    (s_axis_tdata[52:37]),
                .i_psum    (w_psum[t]),
                .i_take    ((t == N - 1) ? w_load : 1'b1),
                .o_psum    (w_psum[t+1])
            );
            assign w_vld[t] = w_psum[t+1].vld;
        end
    endgenerate

    always_comb begin
        if (r_dec == '0) begin
            w_factor = cfd_pkg::DEC_W'(1);
        end else if (r_dec > cfd_pkg::DEC_W'(cfd_pkg::DEC_MAX)) begin
            w_factor = cfd_pkg::DEC_W'(cfd_pkg::DEC_MAX);
        end else begin
            w_factor = r_dec;
        end
        w_phase_p1 = {1'b0, r_phase} + 1'b1;

        n_dec = i_cfg_we ? i_cfg_data : r_dec;

        n_phase = r_phase;
        if (w_is_smp) begin
            n_phase = (w_phase_p1 >= w_factor) ? '0 : w_phase_p1[cfd_pkg::PHASE_W-1:0];
        end

        n_start = w_is_smp & w_emit;

        n_out_vld = r_out_vld;
        if (w_load) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end
    end

    assign w_sat_i = cfd_pkg::sat_q15(w_psum[N].acc_i);
    assign w_sat_q = cfd_pkg::sat_q15(w_psum[N].acc_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec     <= cfd_pkg::DEC_W'(1);
            r_phase   <= '0;
            r_start   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_dec     <= n_dec;
            r_phase   <= n_phase;
            r_start   <= n_start;
            r_out_vld <= n_out_vld;
        end
        if (w_load) begin
            r_out_i    <= w_sat_i.val;
            r_out_q    <= w_sat_q.val;
            r_out_clip <= w_sat_i.clip | w_sat_q.clip;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_q, r_out_i};
    assign m_axis_tuser  = r_out_clip;

endmodule

`default_nettype wire
